// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the LED bounce scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property on every rising edge while reset is released.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
// Checks that a condition never holds while reset is released.
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

// ===== rtl/lbsfp_pkg.sv =====
// Package with types and constants of the LED bounce scanner with fade PWM.
`default_nettype none
package lbsfp_pkg;

    localparam int unsigned BRIGHT_W = 8;
    localparam int unsigned DWELL_W  = 16;
    localparam int unsigned FADE_W   = 8;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned LED_ON_W = 5;
    localparam int unsigned SCAN_W   = 3;
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 8;

    localparam logic [BRIGHT_W-1:0] FULL_ON    = 8'hFF;
    localparam logic [BRIGHT_W-1:0] FADE_START = 8'hFE;
    localparam logic [FADE_W-1:0]   FADE_MAX   = 8'd253;

    localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd975;
    localparam logic [FADE_W-1:0]  FADE_RESET  = 8'd20;

    // Configuration register indexes.
    localparam logic REG_DWELL_TICKS   = 1'b0;
    localparam logic REG_FADE_INTERVAL = 1'b1;

    // Per-tick control broadcast from the controller to every cell.
    typedef struct packed {
        logic                tick;
        logic                advance;
        logic                move_up;
        logic                fade;
        logic [BRIGHT_W-1:0] cmp_phase;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/lbsfp_cell.sv =====
// One LED cell: holds a brightness and the scan token, drives its PWM bit.
`default_nettype none
module lbsfp_cell #(
    parameter bit RESET_LIT = 1'b0
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  lbsfp_pkg::cell_ctrl_t        ctrl,
    input  wire                          tok_in,
    output logic                         tok_out,
    output logic                         drive
);

    logic [lbsfp_pkg::BRIGHT_W-1:0] bright_reg;
    logic [lbsfp_pkg::BRIGHT_W-1:0] bright_next;
    logic [lbsfp_pkg::BRIGHT_W-1:0] b_adv;
    logic [lbsfp_pkg::BRIGHT_W-1:0] b_fade;
    logic                           tok_reg;
    logic                           tok_next;

    // Scan step first, then the fade step, as one tick.
    always_comb begin
        b_adv = bright_reg;
        if (ctrl.advance && tok_reg) begin
            b_adv = lbsfp_pkg::FADE_START;
        end
        if (ctrl.advance && tok_in) begin
            b_adv = lbsfp_pkg::FULL_ON;
        end
        if (ctrl.fade && (b_adv != '0) && (b_adv != lbsfp_pkg::FULL_ON)) begin
            b_fade = b_adv - lbsfp_pkg::BRIGHT_W'(1);
        end else begin
            b_fade = b_adv;
        end
        bright_next = ctrl.tick ? b_fade : bright_reg;
        tok_next    = (ctrl.tick && ctrl.advance) ? tok_in : tok_reg;
    end

    // The PWM compare sees the brightness that this tick leaves.
    assign drive   = ctrl.cmp_phase < bright_next;
    assign tok_out = tok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg <= RESET_LIT ? lbsfp_pkg::FULL_ON : '0;
            tok_reg    <= RESET_LIT;
        end else begin
            bright_reg <= bright_next;
            tok_reg    <= tok_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/lbsfp_ctrl.sv =====
// Controller: configuration, dwell and fade counters, PWM phase, scan position.
`default_nettype none
module lbsfp_ctrl #(
    parameter int unsigned NUM_LEDS = 5,
    parameter int unsigned POS_W    = 3
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_wr_en,
    input  wire                              cfg_addr,
    input  wire  [lbsfp_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire                              accept,
    input  wire                              tick,
    output lbsfp_pkg::cell_ctrl_t            ctrl,
    output logic [POS_W-1:0]                 cur_pos,
    output logic [lbsfp_pkg::SCAN_W-1:0]     scan_pos
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_LEDS - 1);

    logic [lbsfp_pkg::DWELL_W-1:0]  dwell_ticks_reg;
    logic [lbsfp_pkg::FADE_W-1:0]   fade_interval_reg;
    logic [lbsfp_pkg::DWELL_W-1:0]  dwell_reg;
    logic [lbsfp_pkg::DWELL_W-1:0]  dwell_next;
    logic [lbsfp_pkg::FADE_W-1:0]   fade_cnt_reg;
    logic [lbsfp_pkg::FADE_W-1:0]   fade_cnt_next;
    logic [lbsfp_pkg::BRIGHT_W-1:0] phase_reg;
    logic [lbsfp_pkg::BRIGHT_W-1:0] phase_next;
    logic [POS_W-1:0]               cur_reg;
    logic [POS_W-1:0]               cur_next;
    logic                           down_reg;
    logic                           down_next;
    logic [lbsfp_pkg::DWELL_W:0]    dwell_inc;
    logic [lbsfp_pkg::FADE_W-1:0]   fade_limit;
    logic                           step;
    logic                           adv;
    logic                           fire;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dwell_ticks_reg   <= lbsfp_pkg::DWELL_RESET;
            fade_interval_reg <= lbsfp_pkg::FADE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                lbsfp_pkg::REG_DWELL_TICKS:
                    dwell_ticks_reg <= cfg_wdata;
                lbsfp_pkg::REG_FADE_INTERVAL:
                    fade_interval_reg <= cfg_wdata[lbsfp_pkg::FADE_W-1:0];
                default: ;
            endcase
        end
    end

    // Tick decisions: dwell expiry and fade firing.
    always_comb begin
        step       = accept && tick;
        dwell_inc  = {1'b0, dwell_reg} + (lbsfp_pkg::DWELL_W+1)'(1);
        adv        = dwell_inc >= {1'b0, dwell_ticks_reg};
        fade_limit = (fade_interval_reg > lbsfp_pkg::FADE_MAX) ?
                     lbsfp_pkg::FADE_MAX : fade_interval_reg;
        fire       = fade_cnt_reg > fade_limit;
    end

    // Next state of the counters and the bounce position.
    always_comb begin
        dwell_next    = dwell_reg;
        fade_cnt_next = fade_cnt_reg;
        phase_next    = phase_reg;
        cur_next      = cur_reg;
        down_next     = down_reg;
        if (step) begin
            dwell_next    = adv ? '0 : dwell_inc[lbsfp_pkg::DWELL_W-1:0];
            fade_cnt_next = fire ? '0 : fade_cnt_reg + lbsfp_pkg::FADE_W'(1);
            phase_next    = phase_reg + lbsfp_pkg::BRIGHT_W'(1);
            if (adv) begin
                if (!down_reg) begin
                    cur_next = cur_reg + POS_W'(1);
                    if (cur_next == LAST_POS) begin
                        down_next = 1'b1;
                    end
                end else begin
                    cur_next = cur_reg - POS_W'(1);
                    if (cur_next == '0) begin
                        down_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dwell_reg    <= '0;
            fade_cnt_reg <= '0;
            phase_reg    <= '0;
            cur_reg      <= '0;
            down_reg     <= 1'b0;
        end else begin
            dwell_reg    <= dwell_next;
            fade_cnt_reg <= fade_cnt_next;
            phase_reg    <= phase_next;
            cur_reg      <= cur_next;
            down_reg     <= down_next;
        end
    end

    // Broadcast to the cells; without a tick the last phase is compared again.
    always_comb begin
        ctrl.tick      = step;
        ctrl.advance   = adv;
        ctrl.move_up   = !down_reg;
        ctrl.fade      = fire;
        ctrl.cmp_phase = tick ? phase_reg : phase_reg - lbsfp_pkg::BRIGHT_W'(1);
    end

    assign cur_pos = cur_reg;

    // Reported position is the updated index, cut to its low bits or zero-extended.
    generate
        if (POS_W >= lbsfp_pkg::SCAN_W) begin : g_scan_trunc
            assign scan_pos = cur_next[lbsfp_pkg::SCAN_W-1:0];
        end else begin : g_scan_ext
            assign scan_pos = lbsfp_pkg::SCAN_W'(cur_next);
        end
    endgenerate

endmodule
`default_nettype wire

// ===== rtl/led_bounce_scanner_fade_pwm.sv =====
// Top level of the LED bounce scanner with fading trails and software PWM.
//
// Each input transfer on the s_ channel carries one bit, tick. A tick of one
// advances the dwell counter (moving the lit LED along the bounce when it
// expires), fades trailing LEDs every (fade_interval+2)th tick (cap 253), and
// compares every brightness with the tick-stepped 8-bit PWM phase. A tick
// of zero changes nothing and reports the drive of the last tick again.
// Every input transfer yields exactly one output transfer on the m_ channel
// with the LED drive bits and the index of the fully lit LED.
// The result sits in the output register in the cycle after the input
// transfer. One item is taken per cycle while the receiver keeps up; the
// row of LED cells and the counters finish a whole tick in that cycle.
// When the receiver stalls, the result holds in the output register and
// s_tready drops until it is taken; s_tready is high whenever the output
// register is empty or being emptied in the same cycle. Reset (aresetn low,
// synchronous) lights LED 0 fully, turns the others off, clears all counters
// and loads dwell_ticks = 975, fade_interval = 20. The user writes registers
// through cfg_wr_en / cfg_addr / cfg_wdata while idle; it is not enforced.
`default_nettype none
`include "assert_macros.svh"
module led_bounce_scanner_fade_pwm #(
    parameter int unsigned NUM_LEDS = 5
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_wr_en,
    input  wire                               cfg_addr,
    input  wire  [lbsfp_pkg::CFG_W-1:0]       cfg_wdata,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [lbsfp_pkg::S_DATA_W-1:0]    s_tdata,   // [0] tick
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [lbsfp_pkg::M_DATA_W-1:0]    m_tdata    // [4:0] led_on, [7:5] scan_position
);

    localparam int unsigned POS_W = (NUM_LEDS > 2) ? $clog2(NUM_LEDS) : 1;

    lbsfp_pkg::cell_ctrl_t             ctrl;
    logic [POS_W-1:0]                  cur_pos;
    logic [lbsfp_pkg::SCAN_W-1:0]      scan_pos;
    logic [NUM_LEDS-1:0]               tok;
    logic [NUM_LEDS-1:0]               drive;
    logic [lbsfp_pkg::LED_ON_W-1:0]    led_on;
    logic                              accept;
    logic                              m_valid_reg;
    logic                              m_valid_next;
    logic [lbsfp_pkg::M_DATA_W-1:0]    m_data_reg;
    logic [lbsfp_pkg::M_DATA_W-1:0]    m_data_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    lbsfp_ctrl #(
        .NUM_LEDS (NUM_LEDS),
        .POS_W    (POS_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .tick      (s_tdata[0]),
        .ctrl      (ctrl),
        .cur_pos   (cur_pos),
        .scan_pos  (scan_pos)
    );

    // Row of cells; the scan token moves to the left or right neighbor.
    generate
        for (genvar i = 0; i < NUM_LEDS; i++) begin : g_cell
            logic from_left;
            logic from_right;
            if (i == 0) begin : g_first
                assign from_left = 1'b0;
            end else begin : g_mid_l
                assign from_left = tok[i-1];
            end
            if (i == NUM_LEDS - 1) begin : g_last
                assign from_right = 1'b0;
            end else begin : g_mid_r
                assign from_right = tok[i+1];
            end
            lbsfp_cell #(
                .RESET_LIT (i == 0)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .tok_in  (ctrl.move_up ? from_left : from_right),
                .tok_out (tok[i]),
                .drive   (drive[i])
            );
        end
    endgenerate

    // Only the first five LEDs are reported.
    generate
        for (genvar j = 0; j < lbsfp_pkg::LED_ON_W; j++) begin : g_led_on
            if (j < NUM_LEDS) begin : g_used
                assign led_on[j] = drive[j];
            end else begin : g_unused
                assign led_on[j] = 1'b0;
            end
        end
    endgenerate

    // Output register: loads on an input transfer, empties on an output transfer.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = {scan_pos, led_on};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Exactly one cell holds the scan token, and it sits at the tracked position.
    `ASSERT_CLK(a_one_token, aclk, aresetn, $onehot(tok))
    `ASSERT_CLK(a_token_at_pos, aclk, aresetn, tok[cur_pos])
    // Every input transfer leaves a result waiting in the next cycle.
    `ASSERT_CLK(a_result_follows, aclk, aresetn, accept |=> m_tvalid)

endmodule
`default_nettype wire
